[sv/iau_pkg.sv]
// Shared codes, types and helpers of the interval arithmetic unit.
package iau_pkg;

  localparam logic [3:0] CMD_ADD      = 4'd0;
  localparam logic [3:0] CMD_SCALE    = 4'd1;
  localparam logic [3:0] CMD_DIVIDE   = 4'd2;
  localparam logic [3:0] CMD_SAR      = 4'd3;
  localparam logic [3:0] CMD_SHR      = 4'd4;
  localparam logic [3:0] CMD_SUM      = 4'd5;
  localparam logic [3:0] CMD_PRODUCT  = 4'd6;
  localparam logic [3:0] CMD_DIFF     = 4'd7;
  localparam logic [3:0] CMD_CLIP     = 4'd8;
  localparam logic [3:0] CMD_CONTAINS = 4'd9;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_INVERTED = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP, OP_ADD, OP_SCALE, OP_DIVIDE, OP_SAR, OP_SHR,
    OP_SUM, OP_PRODUCT, OP_DIFF, OP_CLIP, OP_CONTAINS
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        k_zero;
    logic        sar_bad;
    logic        shr_bad;
    logic [63:0] al;
    logic [63:0] ah;
    logic [63:0] bl;
    logic [63:0] bh;
    logic [31:0] k;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [63:0] rl;
    logic [63:0] rh;
    logic [1:0]  st;
    logic        inside_res;
  } res_t;

  // Keep the low w bits and sign-extend them to 64.
  function automatic logic [63:0] sext(input logic [63:0] v, input logic [6:0] w);
    logic [63:0] r;
    logic        s;
    s = v[6'(w - 7'd1)];
    for (int i = 0; i < 64; i++) begin
      r[i] = (i < int'(w)) ? v[i] : s;
    end
    return r;
  endfunction

  function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [63:0] smin(input logic [63:0] a, input logic [63:0] b);
    return slt(b, a) ? b : a;
  endfunction

  function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
    return slt(a, b) ? b : a;
  endfunction

endpackage

[sv/iau_front.sv]
// Front end: accepts transactions, classifies commands and queues them.
module iau_front #(
  parameter int BOUND_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [3:0]          command_i,
  input  logic [63:0]         a_low_i,
  input  logic [63:0]         a_high_i,
  input  logic [63:0]         b_low_i,
  input  logic [63:0]         b_high_i,
  input  logic [31:0]         operand_k_i,
  output iau_pkg::head_t      head_o,
  input  logic                pop_i
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam logic [6:0] WB = 7'(BOUND_WIDTH);

  iau_pkg::item_t item;
  iau_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PW:0]    cnt_q;
  logic           wr_en, rd_en;

  always_comb begin
    item.al      = iau_pkg::sext(a_low_i, WB);
    item.ah      = iau_pkg::sext(a_high_i, WB);
    item.bl      = iau_pkg::sext(b_low_i, WB);
    item.bh      = iau_pkg::sext(b_high_i, WB);
    item.k       = operand_k_i;
    item.k_zero  = (operand_k_i == 32'd0);
    item.sar_bad = operand_k_i[31] || (operand_k_i[30:0] > 31'(BOUND_WIDTH - 2));
    item.shr_bad = operand_k_i[31] || (operand_k_i[30:0] > 31'd31);
    unique case (command_i)
      iau_pkg::CMD_ADD:      item.op = iau_pkg::OP_ADD;
      iau_pkg::CMD_SCALE:    item.op = iau_pkg::OP_SCALE;
      iau_pkg::CMD_DIVIDE:   item.op = iau_pkg::OP_DIVIDE;
      iau_pkg::CMD_SAR:      item.op = iau_pkg::OP_SAR;
      iau_pkg::CMD_SHR:      item.op = iau_pkg::OP_SHR;
      iau_pkg::CMD_SUM:      item.op = iau_pkg::OP_SUM;
      iau_pkg::CMD_PRODUCT:  item.op = iau_pkg::OP_PRODUCT;
      iau_pkg::CMD_DIFF:     item.op = iau_pkg::OP_DIFF;
      iau_pkg::CMD_CLIP:     item.op = iau_pkg::OP_CLIP;
      iau_pkg::CMD_CONTAINS: item.op = iau_pkg::OP_CONTAINS;
      default:               item.op = iau_pkg::OP_NOP;
    endcase
  end

  assign full_o       = (cnt_q == (PW+1)'(DEPTH));
  assign wr_en        = push_i && !full_o;
  assign rd_en        = pop_i && head_o.valid;
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= item;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(DEPTH)) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid) else $error("pop from empty queue");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full queue lost an entry");
`endif

endmodule

[sv/iau_back.sv]
// Back end: execution pipeline with multiplier, divider and output register.
module iau_back #(
  parameter int BOUND_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iau_pkg::head_t head_i,
  output logic           q_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output iau_pkg::res_t  res_o
);

  localparam int W   = BOUND_WIDTH;
  localparam int LAT = W + 2;
  localparam logic [6:0] WB = 7'(W);

  typedef struct packed {
    logic [31:0]  rem;
    logic [W-1:0] work;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [1:0] ln;
    logic [31:0]     d;
    logic [1:0]      qneg;
  } div_stage_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  // One restoring division step: bring in the next dividend bit.
  function automatic div_lane_t div_step(input div_lane_t l, input logic [31:0] d);
    div_lane_t   r;
    logic [32:0] t;
    logic        ge;
    t      = {l.rem, l.work[W-1]};
    ge     = (t >= {1'b0, d});
    r.rem  = ge ? 32'(t - {1'b0, d}) : t[31:0];
    r.work = {l.work[W-2:0], ge};
    return r;
  endfunction

  // Truncating division by 2^sh.
  function automatic logic [63:0] sar_div(input logic [63:0] v, input logic [5:0] sh);
    logic [63:0] mag, s;
    mag = v[63] ? -v : v;
    s   = mag >> sh;
    return v[63] ? -s : s;
  endfunction

  iau_pkg::item_t it;
  logic           en;

  logic             v_q   [1:LAT];
  iau_pkg::op_e     op_q  [1:LAT];
  iau_pkg::res_t    res_q [1:LAT];
  iau_pkg::res_t    res_d [1:LAT];
  iau_pkg::res_t    r0;

  pp_t         pp_d [4];
  pp_t         pp_q [4];
  logic [63:0] val_q [4];
  logic [63:0] mn_q [2];
  logic [63:0] mx_q [2];

  div_stage_t  div_src [0:W-1];
  div_stage_t  div_q   [1:W];
  logic [63:0] qs_q    [2];

  iau_pkg::res_t out_q;
  logic          out_v_q;

  logic [63:0] ks, sl, sh, x [4], y [4];
  logic [31:0] kmag, pl, ph;

  assign it      = head_i.item;
  assign en      = !out_v_q || pop_i;
  assign q_pop_o = en && head_i.valid;
  assign empty_o = !out_v_q;
  assign res_o   = out_q;

  always_comb begin
    ks   = {{32{it.k[31]}}, it.k};
    kmag = it.k[31] ? 32'(~it.k + 32'd1) : it.k;
    sl   = iau_pkg::sext(sar_div(it.al, it.k[5:0]), WB);
    sh   = iau_pkg::sext(sar_div(it.ah, it.k[5:0]), WB);
    pl   = it.al[31:0] >> it.k[4:0];
    ph   = it.ah[31:0] >> it.k[4:0];
    r0   = '0;
    unique case (it.op)
      iau_pkg::OP_ADD: begin
        r0.rl = iau_pkg::sext(it.al + ks, WB);
        r0.rh = iau_pkg::sext(it.ah + ks, WB);
      end
      iau_pkg::OP_DIVIDE: begin
        if (it.k_zero) r0.st = iau_pkg::ST_ZERO_DIV;
      end
      iau_pkg::OP_SAR: begin
        if (it.sar_bad) begin
          r0.st = iau_pkg::ST_RANGE;
        end else begin
          r0.rl = sl;
          r0.rh = sh;
          if (iau_pkg::slt(sh, sl)) r0.st = iau_pkg::ST_INVERTED;
        end
      end
      iau_pkg::OP_SHR: begin
        if (it.shr_bad) begin
          r0.st = iau_pkg::ST_RANGE;
        end else begin
          r0.rl = iau_pkg::sext({32'd0, (pl > ph) ? ph : pl}, WB);
          r0.rh = iau_pkg::sext({32'd0, (pl > ph) ? pl : ph}, WB);
        end
      end
      iau_pkg::OP_SUM: begin
        r0.rl = iau_pkg::sext(it.al + it.bl, WB);
        r0.rh = iau_pkg::sext(it.ah + it.bh, WB);
      end
      iau_pkg::OP_DIFF: begin
        r0.rl = iau_pkg::sext(it.al - it.bh, WB);
        r0.rh = iau_pkg::sext(it.ah - it.bl, WB);
      end
      iau_pkg::OP_CLIP: begin
        r0.rl = iau_pkg::smax(it.al, it.bl);
        r0.rh = iau_pkg::smin(it.ah, it.bh);
      end
      iau_pkg::OP_CONTAINS: begin
        r0.inside_res = !iau_pkg::slt(ks, it.al) && !iau_pkg::slt(it.ah, ks);
      end
      default: ;
    endcase
  end

  // Scale reuses the product datapath with k in place of both B bounds.
  always_comb begin
    x[0] = it.al;
    x[1] = it.al;
    x[2] = it.ah;
    x[3] = it.ah;
    y[0] = (it.op == iau_pkg::OP_SCALE) ? ks : it.bl;
    y[1] = (it.op == iau_pkg::OP_SCALE) ? ks : it.bh;
    y[2] = (it.op == iau_pkg::OP_SCALE) ? ks : it.bl;
    y[3] = (it.op == iau_pkg::OP_SCALE) ? ks : it.bh;
    for (int i = 0; i < 4; i++) begin
      pp_d[i].ll = x[i][31:0] * y[i][31:0];
      pp_d[i].lh = x[i][31:0] * y[i][63:32];
      pp_d[i].hl = x[i][63:32] * y[i][31:0];
    end
  end

  always_comb begin
    div_src[0].d       = kmag;
    div_src[0].qneg[0] = it.al[63] ^ it.k[31];
    div_src[0].qneg[1] = it.ah[63] ^ it.k[31];
    div_src[0].ln[0].rem  = '0;
    div_src[0].ln[1].rem  = '0;
    div_src[0].ln[0].work = W'(it.al[63] ? -it.al : it.al);
    div_src[0].ln[1].work = W'(it.ah[63] ? -it.ah : it.ah);
    for (int i = 1; i < W; i++) div_src[i] = div_q[i];
  end

  always_comb begin
    res_d[1] = r0;
    for (int s = 2; s <= LAT; s++) res_d[s] = res_q[s-1];
    if (op_q[3] == iau_pkg::OP_SCALE || op_q[3] == iau_pkg::OP_PRODUCT) begin
      res_d[4].rl = iau_pkg::smin(mn_q[0], mn_q[1]);
      res_d[4].rh = iau_pkg::smax(mx_q[0], mx_q[1]);
    end
    if (op_q[LAT-1] == iau_pkg::OP_DIVIDE && res_q[LAT-1].st != iau_pkg::ST_ZERO_DIV) begin
      res_d[LAT].rl = iau_pkg::smin(qs_q[0], qs_q[1]);
      res_d[LAT].rh = iau_pkg::smax(qs_q[0], qs_q[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= LAT; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[1] <= head_i.valid;
      for (int s = 2; s <= LAT; s++) v_q[s] <= v_q[s-1];
      out_v_q <= v_q[LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[1] <= it.op;
      for (int s = 2; s <= LAT; s++) op_q[s] <= op_q[s-1];
      for (int s = 1; s <= LAT; s++) res_q[s] <= res_d[s];
      for (int i = 0; i < 4; i++) begin
        pp_q[i]  <= pp_d[i];
        val_q[i] <= iau_pkg::sext(pp_q[i].ll + {pp_q[i].lh + pp_q[i].hl, 32'd0}, WB);
      end
      mn_q[0] <= iau_pkg::smin(val_q[0], val_q[1]);
      mn_q[1] <= iau_pkg::smin(val_q[2], val_q[3]);
      mx_q[0] <= iau_pkg::smax(val_q[0], val_q[1]);
      mx_q[1] <= iau_pkg::smax(val_q[2], val_q[3]);
      for (int i = 0; i < W; i++) begin
        div_q[i+1].ln[0] <= div_step(div_src[i].ln[0], div_src[i].d);
        div_q[i+1].ln[1] <= div_step(div_src[i].ln[1], div_src[i].d);
        div_q[i+1].d     <= div_src[i].d;
        div_q[i+1].qneg  <= div_src[i].qneg;
      end
      for (int j = 0; j < 2; j++) begin
        qs_q[j] <= iau_pkg::sext(div_q[W].qneg[j] ? -64'(div_q[W].ln[j].work)
                                                  : 64'(div_q[W].ln[j].work), WB);
      end
      if (v_q[LAT]) out_q <= res_q[LAT];
    end
  end

`ifndef NO_ASSERTIONS
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> head_i.valid) else $error("took an empty queue head");
  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAT] && !en) |=> v_q[LAT]) else $error("stalled transaction dropped");
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && op_q[1] == iau_pkg::OP_DIVIDE && res_q[1].st == iau_pkg::ST_ZERO_DIV)
      |-> (res_q[1].rl == '0 && res_q[1].rh == '0))
    else $error("zero divisor result not cleared");
`endif

endmodule

[sv/interval_arithmetic_unit.sv]
// Top level of the interval arithmetic unit.
// Usage:
//   Input queue: drive command_i, the A and B bounds and operand_k_i with
//   push_i; a transaction is taken at a clock edge where push_i is high and
//   full_o is low. A two-entry input queue decouples the front end.
//   Result queue: while empty_o is low, r_low_o, r_high_o, status_o and
//   inside_res_o show the oldest result; pop_i takes it at the same edge.
//   Results leave in the order transactions were pushed, one per push.
//   Throughput: one transaction per cycle when the result side does not
//   stall. The pipeline depth is set by the divider, one quotient bit per
//   pipeline stage (BOUND_WIDTH stages), plus sign fixup, min/max and the
//   output register.
//   When the receiver stalls, the whole execution pipeline holds; the input
//   queue fills and full_o rises two transactions later.
//   Reset (rst_ni low) empties both queues and the pipeline at once.
module interval_arithmetic_unit #(
  parameter int BOUND_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [3:0]         command_i,
  input  logic signed [63:0] a_low_i,
  input  logic signed [63:0] a_high_i,
  input  logic signed [63:0] b_low_i,
  input  logic signed [63:0] b_high_i,
  input  logic signed [31:0] operand_k_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [63:0] r_low_o,
  output logic signed [63:0] r_high_o,
  output logic [1:0]         status_o,
  output logic               inside_res_o
);

  iau_pkg::head_t head;
  iau_pkg::res_t  res;
  logic           q_pop;

  iau_front #(.BOUND_WIDTH(BOUND_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .command_i   (command_i),
    .a_low_i     (a_low_i),
    .a_high_i    (a_high_i),
    .b_low_i     (b_low_i),
    .b_high_i    (b_high_i),
    .operand_k_i (operand_k_i),
    .head_o      (head),
    .pop_i       (q_pop)
  );

  iau_back #(.BOUND_WIDTH(BOUND_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .q_pop_o (q_pop),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .res_o   (res)
  );

  assign r_low_o      = res.rl;
  assign r_high_o     = res.rh;
  assign status_o     = res.st;
  assign inside_res_o = res.inside_res;

endmodule
